// File: hw/rtl/ddde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddde_pkg
// Shared constants, types and helpers of the dense Dijkstra distance engine.
// ----------------------------------------------------------------------------
package ddde_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int WEIGHT_BITS  = 16;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int VC_W         = 7;
	localparam int DIST_W       = 31;
	localparam int WORD_W       = DIST_W + 1;
	localparam int ADJ_AW       = 2 * VIDX_W;
	localparam int ADJ_DEPTH    = 1 << ADJ_AW;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [VC_W-1:0]   VC_RESET = VC_W'(64);

	localparam logic KIND_EDGE = 1'b0;
	localparam logic KIND_RUN  = 1'b1;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INIT,
		S_RELAX,
		S_DRAIN,
		S_NEXT,
		S_OUT_RD,
		S_OUT_LD
	} ddde_state_t;

	// Round context and the fetched entry, handed to the relax unit.
	typedef struct packed {
		logic [WORD_W-1:0]      word;
		logic [WEIGHT_BITS-1:0] weight;
		logic                   is_pick;
		logic                   expand;
		logic [DIST_W-1:0]      pick_dist;
		logic                   found;
		logic [DIST_W-1:0]      min_dist;
	} relax_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] wr_word;
		logic              take;
		logic [DIST_W-1:0] new_dist;
	} relax_out_t;

	// Only the upper triangle of the symmetric matrix is stored.
	function automatic logic [ADJ_AW-1:0] adj_addr(input logic [VIDX_W-1:0] a,
	                                               input logic [VIDX_W-1:0] b);
		adj_addr = (a < b) ? {a, b} : {b, a};
	endfunction

endpackage : ddde_pkg
`default_nettype wire

// File: hw/rtl/ddde_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddde_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ddde_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule : ddde_ram
`default_nettype wire

// File: hw/rtl/ddde_relax.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddde_relax
// Relax one fetched vertex against the current pick and track the next pick.
// ----------------------------------------------------------------------------
module ddde_relax
	import ddde_pkg::*;
(
	input  wire relax_in_t  rin,
	output relax_out_t      rout
);

	logic              done_j;
	logic [DIST_W-1:0] dist_j;
	logic [DIST_W:0]   sum;
	logic [DIST_W-1:0] sat;
	logic              relax_ok;
	logic [DIST_W-1:0] new_dist;
	logic              cand;

	always_comb begin
		done_j   = rin.word[WORD_W-1];
		dist_j   = rin.word[DIST_W-1:0];
		sum      = {1'b0, rin.pick_dist} + (DIST_W+1)'(rin.weight);
		// saturate path sums at the maximum
		sat      = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
		relax_ok = rin.expand && (rin.weight != '0) && !done_j && !rin.is_pick;
		new_dist = (relax_ok && (sat < dist_j)) ? sat : dist_j;
		cand     = !done_j && !rin.is_pick;

		rout.new_dist = new_dist;
		rout.take     = cand && (!rin.found || (new_dist < rin.min_dist));
		rout.wr_word  = rin.is_pick ? {1'b1, dist_j} : {done_j, new_dist};
	end

endmodule : ddde_relax
`default_nettype wire

// File: hw/rtl/dense_dijkstra_distance_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dense_dijkstra_distance_engine
// Adjacency-matrix Dijkstra engine: loads edges, reports distances from vertex 0.
// ----------------------------------------------------------------------------
// Input beats carry either an edge (tuser = 0) or a run request (tuser = 1).
// An edge beat stores its weight once, in the upper triangle of a 4096-entry
// matrix RAM; weight zero removes the edge. A run beat, for n active vertices
// (vertex_count clamped to 2..64), first resets the distance RAM, then runs
// n-1 rounds, one matrix read and one distance read-modify-write per cycle,
// then sends one result beat per cycle while m_tready is high, in ascending
// vertex order, tlast on the final vertex.
// Each round relaxes the neighbors of the current pick and finds the next pick
// (least distance, lowest index on ties) in the same sweep. Unreachable
// vertices report 2147483647. After reset, a clearing pass over all 4096
// entries zeroes the matrix; no input beat is taken until it ends, configuration
// writes are taken at any time. vertex_count may only be written while idle.
// ----------------------------------------------------------------------------
module dense_dijkstra_distance_engine
	import ddde_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration
	input  wire logic             cfg_we,
	input  wire logic [VC_W-1:0]  cfg_wdata,     // vertex_count
	// input stream
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [31:0]      s_tdata,       // [5:0] from_vertex, [11:6] to_vertex,
	                                             // [27:12] weight, [31:28] zero
	input  wire logic             s_tuser,       // kind
	// result stream
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [39:0]      m_tdata,       // [5:0] vertex, [36:6] distance,
	                                             // [39:37] zero
	output logic                  m_tlast        // last
);

	// ---------------------------------------------------------------- state
	ddde_state_t state_q, state_d;

	logic [VC_W-1:0]        vertex_count_q;
	logic [ADJ_AW-1:0]      clr_q;
	logic [VIDX_W-1:0]      idx_q;       // init / sweep / output index
	logic [VIDX_W-1:0]      round_q;
	logic [VIDX_W-1:0]      pick_q;
	logic [DIST_W-1:0]      pick_dist_q;
	logic                   expand_q;
	logic                   found_q;
	logic [VIDX_W-1:0]      min_idx_q;
	logic [DIST_W-1:0]      min_dist_q;
	logic                   valid_s1;
	logic [VIDX_W-1:0]      idx_s1;
	logic                   m_tvalid_q;
	logic                   m_tlast_q;
	logic [VIDX_W-1:0]      m_vertex_q;
	logic [DIST_W-1:0]      m_dist_q;

	// ------------------------------------------------------ active count
	logic [CNT_W-1:0]  n_act;
	logic [VIDX_W-1:0] nm1;
	logic [VIDX_W-1:0] nm2;

	always_comb begin
		if (vertex_count_q < VC_W'(2)) begin
			n_act = CNT_W'(2);
		end else if (vertex_count_q > VC_W'(MAX_VERTICES)) begin
			n_act = CNT_W'(MAX_VERTICES);
		end else begin
			n_act = CNT_W'(vertex_count_q);
		end
		nm1 = VIDX_W'(n_act - CNT_W'(1));
		nm2 = VIDX_W'(n_act - CNT_W'(2));
	end

	// ----------------------------------------------------- input decode
	logic [VIDX_W-1:0]      in_from;
	logic [VIDX_W-1:0]      in_to;
	logic [WEIGHT_BITS-1:0] in_weight;
	logic                   in_acc;
	logic                   edge_acc;
	logic                   run_acc;

	assign in_from   = s_tdata[5:0];
	assign in_to     = s_tdata[11:6];
	assign in_weight = s_tdata[27:12];
	assign s_tready  = (state_q == S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign edge_acc  = in_acc && (s_tuser == KIND_EDGE);
	assign run_acc   = in_acc && (s_tuser == KIND_RUN);

	// --------------------------------------------------------- output reg
	logic out_free;
	logic out_load;

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == S_OUT_LD) && out_free;

	// -------------------------------------------------------- memories
	logic                   adj_we;
	logic [ADJ_AW-1:0]      adj_waddr;
	logic [WEIGHT_BITS-1:0] adj_wdata;
	logic [ADJ_AW-1:0]      adj_raddr;
	logic [WEIGHT_BITS-1:0] adj_rdata;

	logic                   dist_we;
	logic [VIDX_W-1:0]      dist_waddr;
	logic [WORD_W-1:0]      dist_wdata;
	logic [VIDX_W-1:0]      dist_raddr;
	logic [WORD_W-1:0]      dist_rdata;

	relax_in_t  rin;
	relax_out_t rout;

	// clear the matrix after reset, else store one edge per beat
	assign adj_we    = (state_q == S_CLEAR) || edge_acc;
	assign adj_waddr = (state_q == S_CLEAR) ? clr_q : adj_addr(in_from, in_to);
	assign adj_wdata = (state_q == S_CLEAR) ? '0 : in_weight;
	assign adj_raddr = adj_addr(pick_q, idx_q);

	ddde_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (ADJ_DEPTH)
	) u_adj_ram (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	// distance word: {done mark, distance}
	always_comb begin
		if (state_q == S_INIT) begin
			dist_we    = 1'b1;
			dist_waddr = idx_q;
			dist_wdata = {1'b0, (idx_q == '0) ? DIST_W'(0) : DIST_MAX};
		end else begin
			dist_we    = valid_s1;
			dist_waddr = idx_s1;
			dist_wdata = rout.wr_word;
		end
		// in the output stage, advance the read only when a beat is loaded
		if (out_load) begin
			dist_raddr = idx_q + VIDX_W'(1);
		end else begin
			dist_raddr = idx_q;
		end
	end

	ddde_ram #(
		.WIDTH (WORD_W),
		.DEPTH (MAX_VERTICES)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	// ------------------------------------------------------- relax unit
	always_comb begin
		rin.word      = dist_rdata;
		rin.weight    = adj_rdata;
		rin.is_pick   = (idx_s1 == pick_q);
		rin.expand    = expand_q;
		rin.pick_dist = pick_dist_q;
		rin.found     = found_q;
		rin.min_dist  = min_dist_q;
	end

	ddde_relax u_relax (
		.rin  (rin),
		.rout (rout)
	);

	// ---------------------------------------------------- state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == '1) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (run_acc) state_d = S_INIT;
			end
			S_INIT: begin
				if (idx_q == nm1) state_d = S_RELAX;
			end
			S_RELAX: begin
				if (idx_q == nm1) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_NEXT;
			end
			S_NEXT: begin
				state_d = (round_q == nm2) ? S_OUT_RD : S_RELAX;
			end
			S_OUT_RD: begin
				state_d = S_OUT_LD;
			end
			S_OUT_LD: begin
				if (out_load && (idx_q == nm1)) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------- control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VC_RESET;
			clr_q          <= '0;
			idx_q          <= '0;
			round_q        <= '0;
			pick_q         <= '0;
			expand_q       <= 1'b0;
			found_q        <= 1'b0;
			valid_s1       <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_we) vertex_count_q <= cfg_wdata;
			if (state_q == S_CLEAR) clr_q <= clr_q + ADJ_AW'(1);

			valid_s1 <= (state_q == S_RELAX);

			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
				end
				S_INIT: begin
					idx_q <= idx_q + VIDX_W'(1);
					if (idx_q == nm1) begin
						// round zero expands vertex 0 at distance zero
						idx_q    <= '0;
						round_q  <= '0;
						pick_q   <= '0;
						expand_q <= 1'b1;
						found_q  <= 1'b0;
					end
				end
				S_RELAX: begin
					if (idx_q != nm1) idx_q <= idx_q + VIDX_W'(1);
				end
				S_NEXT: begin
					idx_q    <= '0;
					pick_q   <= min_idx_q;
					expand_q <= (min_dist_q != DIST_MAX);
					found_q  <= 1'b0;
					if (round_q != nm2) round_q <= round_q + VIDX_W'(1);
				end
				S_OUT_LD: begin
					if (out_load) idx_q <= idx_q + VIDX_W'(1);
				end
				default: begin
				end
			endcase

			// track the next pick while the sweep runs
			if (valid_s1 && rout.take) found_q <= 1'b1;

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// --------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (state_q == S_INIT) begin
			pick_dist_q <= '0;
		end else if (state_q == S_NEXT) begin
			pick_dist_q <= min_dist_q;
		end
		if (valid_s1 && rout.take) begin
			min_idx_q  <= idx_s1;
			min_dist_q <= rout.new_dist;
		end
		if (out_load) begin
			m_vertex_q <= idx_q;
			m_dist_q   <= dist_rdata[DIST_W-1:0];
			m_tlast_q  <= (idx_q == nm1);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, m_dist_q, m_vertex_q};
	assign m_tlast  = m_tlast_q;

	// --------------------------------------------------------- assertions
	// The pick stays inside the active range and its expand flag matches it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RELAX || state_q == S_DRAIN) |->
			(pick_q <= nm1 && expand_q == (pick_dist_q != DIST_MAX)))
	else $error("pick out of range or expand flag stale");

	// The matrix is never written while a sweep reads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RELAX || state_q == S_DRAIN || valid_s1) |-> !adj_we)
	else $error("matrix write during a sweep");

	// Distance writes never happen while results are read out.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT_RD || state_q == S_OUT_LD) |-> !dist_we)
	else $error("distance write during readout");

	// A sweep entry is processed in the cycle after its read was issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ($past(state_q) == S_RELAX && idx_s1 == $past(idx_q)))
	else $error("sweep pipeline out of step");

endmodule : dense_dijkstra_distance_engine
`default_nettype wire
